FILE: rtl/tcsd_pkg.sv
// ---------------------------------------------------------------------------
// tcsd_pkg: shared types and constants of the two-channel strided DMA
// Opcodes, result kinds, register map and the result record that travels
// from the segment engine to the result queue.
// ---------------------------------------------------------------------------
package tcsd_pkg;

	// Field widths of the two channels
	localparam int OPCODE_W = 2;
	localparam int INDEX_W  = 5;
	localparam int DATA_W   = 32;
	localparam int KIND_W   = 2;
	localparam int BLEN_W   = 19;

	// Default configuration
	localparam int DEF_SEG_LEN_BITS   = 16;
	localparam int DEF_SEG_COUNT_BITS = 16;
	localparam int DEF_ADDR_BITS      = 32;

	// Number of channels and pending bits
	localparam int NUM_CH  = 2;
	localparam int IRQ_W   = 4;

	// Result queue
	localparam int RQ_DEPTH = 4;
	localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
	localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

	typedef enum logic [OPCODE_W-1:0] {
		OP_WRITE = 2'd0,
		OP_READ  = 2'd1,
		OP_TICK  = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_REG  = 2'd0,
		KIND_RD   = 2'd1,
		KIND_WR   = 2'd2,
		KIND_IDLE = 2'd3
	} kind_t;

	// Register map
	localparam logic [INDEX_W-1:0] REG_CTRL     = 5'd0;
	localparam logic [INDEX_W-1:0] REG_STATUS   = 5'd1;
	localparam logic [INDEX_W-1:0] REG_IRQ_EN   = 5'd2;
	localparam logic [INDEX_W-1:0] REG_IRQ_PEND = 5'd3;
	localparam logic [INDEX_W-1:0] REG_CH0_BASE = 5'd4;
	localparam logic [INDEX_W-1:0] REG_CH1_BASE = 5'd11;
	localparam logic [INDEX_W-1:0] REG_LAST     = 5'd17;

	// Offsets inside one channel's register block
	localparam logic [2:0] OFF_SRC        = 3'd0;
	localparam logic [2:0] OFF_DST        = 3'd1;
	localparam logic [2:0] OFF_SEG_LEN    = 3'd2;
	localparam logic [2:0] OFF_SEG_CNT    = 3'd3;
	localparam logic [2:0] OFF_WIDTH      = 3'd4;
	localparam logic [2:0] OFF_SRC_STRIDE = 3'd5;
	localparam logic [2:0] OFF_DST_STRIDE = 3'd6;

	typedef struct packed {
		kind_t              kind;
		logic               channel;
		logic [DATA_W-1:0]  mem_address;
		logic [BLEN_W-1:0]  byte_length;
		logic [DATA_W-1:0]  read_data;
		logic               last;
		logic               irq;
	} res_t;

	// One processed request: one or two results for the queue
	typedef struct packed {
		logic push;
		logic pair;
		res_t first;
		res_t second;
	} push_t;

endpackage

FILE: rtl/tcsd_req_if.sv
// ---------------------------------------------------------------------------
// tcsd_req_if: request channel of the DMA
// Valid/ready handshake carrying opcode, register index and write data.
// ---------------------------------------------------------------------------
interface tcsd_req_if import tcsd_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [INDEX_W-1:0]  reg_index;
	logic [DATA_W-1:0]   write_data;

	modport source (output valid, output opcode, output reg_index, output write_data,
		input ready);
	modport sink (input valid, input opcode, input reg_index, input write_data,
		output ready);
endinterface

FILE: rtl/tcsd_rsp_if.sv
// ---------------------------------------------------------------------------
// tcsd_rsp_if: result channel of the DMA
// Valid/ready handshake carrying register replies and memory requests.
// ---------------------------------------------------------------------------
interface tcsd_rsp_if import tcsd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic              channel;
	logic [DATA_W-1:0] mem_address;
	logic [BLEN_W-1:0] byte_length;
	logic [DATA_W-1:0] read_data;
	logic              last;
	logic              irq;

	modport source (output valid, output kind, output channel, output mem_address,
		output byte_length, output read_data, output last, output irq, input ready);
	modport sink (input valid, input kind, input channel, input mem_address,
		input byte_length, input read_data, input last, input irq, output ready);
endinterface

FILE: rtl/two_channel_strided_dma.sv
// ---------------------------------------------------------------------------
// two_channel_strided_dma: two-channel strided segment DMA controller
// Register file, round-robin segment engine and memory request generator.
//
// Usage:
//   req channel: one request per handshake: register write, register read,
//   or a tick that advances one busy channel by one segment.
//   rsp channel: a register write, read or unused opcode gives one register
//   reply; a tick gives a memory read request followed by a memory write
//   request, or one idle result when no channel is busy. last marks the
//   final result of a request, irq is sampled after the request took effect.
//   The first result passes the input register, then the register state update
//   and result queue write; a full queue holds the request in the input register.
//   Throughput: one request per cycle for single-result requests while the
//   queue has room; ticks with a busy channel give two results, handed out
//   in turn by the one-wide result port of the four-entry result queue.
//   Reset clears all registers, channel state and the queue.
//   When the receiver stalls, the queue fills and req.ready drops; nothing
//   is lost or repeated.
// ---------------------------------------------------------------------------
module two_channel_strided_dma import tcsd_pkg::*; #(
	parameter int SEG_LEN_BITS   = DEF_SEG_LEN_BITS,
	parameter int SEG_COUNT_BITS = DEF_SEG_COUNT_BITS,
	parameter int ADDR_BITS      = DEF_ADDR_BITS
) (
	input  logic     clk,
	input  logic     arst_n,
	tcsd_req_if.sink   req,
	tcsd_rsp_if.source rsp
);

	logic                valid_s1;
	logic [OPCODE_W-1:0] opcode_s1;
	logic [INDEX_W-1:0]  reg_index_s1;
	logic [DATA_W-1:0]   write_data_s1;
	logic                room;
	logic                fire;
	push_t               push;
	res_t                head;

	// Input register advances when its request is processed
	assign fire      = valid_s1 && room;
	assign req.ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			opcode_s1     <= req.opcode;
			reg_index_s1  <= req.reg_index;
			write_data_s1 <= req.write_data;
		end
	end

	tcsd_core #(
		.SEG_LEN_BITS   (SEG_LEN_BITS),
		.SEG_COUNT_BITS (SEG_COUNT_BITS),
		.ADDR_BITS      (ADDR_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.opcode     (opcode_s1),
		.reg_index  (reg_index_s1),
		.write_data (write_data_s1),
		.push       (push)
	);

	tcsd_res_q u_res_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.out_res   (head)
	);

	// Result fields
	assign rsp.kind        = head.kind;
	assign rsp.channel     = head.channel;
	assign rsp.mem_address = head.mem_address;
	assign rsp.byte_length = head.byte_length;
	assign rsp.read_data   = head.read_data;
	assign rsp.last        = head.last;
	assign rsp.irq         = head.irq;

endmodule

FILE: rtl/tcsd_core.sv
// ---------------------------------------------------------------------------
// tcsd_core: register file and segment engine
// Applies one request per cycle, when fire is high, to the registers and
// channel state and forms the one or two results it causes.
// ---------------------------------------------------------------------------
module tcsd_core import tcsd_pkg::*; #(
	parameter int SEG_LEN_BITS   = DEF_SEG_LEN_BITS,
	parameter int SEG_COUNT_BITS = DEF_SEG_COUNT_BITS,
	parameter int ADDR_BITS      = DEF_ADDR_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  logic [OPCODE_W-1:0] opcode,
	input  logic [INDEX_W-1:0]  reg_index,
	input  logic [DATA_W-1:0]   write_data,
	output push_t               push
);

	// Current addresses wrap at the smaller of the address width and 32 bits
	localparam int CUR_W = (ADDR_BITS < 32) ? ADDR_BITS : 32;
	localparam int SH_W  = (SEG_LEN_BITS + 3 > BLEN_W) ? SEG_LEN_BITS + 3 : BLEN_W;

	// Per-channel configuration
	logic [DATA_W-1:0]         src_start_q  [NUM_CH];
	logic [DATA_W-1:0]         dst_start_q  [NUM_CH];
	logic [SEG_LEN_BITS-1:0]   seg_len_q    [NUM_CH];
	logic [SEG_COUNT_BITS-1:0] seg_cnt_q    [NUM_CH];
	logic [1:0]                width_q      [NUM_CH];
	logic [DATA_W-1:0]         src_stride_q [NUM_CH];
	logic [DATA_W-1:0]         dst_stride_q [NUM_CH];

	// Transfer state
	logic [CUR_W-1:0]          cur_src_q  [NUM_CH];
	logic [CUR_W-1:0]          cur_dst_q  [NUM_CH];
	logic [SEG_COUNT_BITS-1:0] segs_q     [NUM_CH];
	logic [NUM_CH-1:0]         busy_q;
	logic [IRQ_W-1:0]          irq_en_q;
	logic [IRQ_W-1:0]          irq_pend_q;
	logic                      rr_q;

	// Next-state values
	logic [CUR_W-1:0]          cur_src_d [NUM_CH];
	logic [CUR_W-1:0]          cur_dst_d [NUM_CH];
	logic [SEG_COUNT_BITS-1:0] segs_d    [NUM_CH];
	logic [NUM_CH-1:0]         busy_d;
	logic [IRQ_W-1:0]          irq_en_d;
	logic [IRQ_W-1:0]          irq_pend_d;
	logic                      rr_d;

	op_t                       op;
	logic                      ch_hit;
	logic                      ch_sel;
	logic [INDEX_W-1:0]        ch_rel;
	logic [2:0]                ch_off;
	logic                      is_write;
	logic                      tick_act;
	logic                      tc;
	logic [SEG_COUNT_BITS:0]   segs_inc;
	logic [SH_W-1:0]           shifted;
	logic [BLEN_W-1:0]         blen;
	logic [DATA_W-1:0]         rd_val;
	logic                      irq_now;

	assign op       = op_t'(opcode);
	assign is_write = fire && (op == OP_WRITE);

	// Channel register decode
	always_comb begin
		ch_hit = 1'b0;
		ch_sel = 1'b0;
		ch_rel = '0;
		if (reg_index >= REG_CH0_BASE && reg_index < REG_CH1_BASE) begin
			ch_hit = 1'b1;
			ch_rel = reg_index - REG_CH0_BASE;
		end else if (reg_index >= REG_CH1_BASE && reg_index <= REG_LAST) begin
			ch_hit = 1'b1;
			ch_sel = 1'b1;
			ch_rel = reg_index - REG_CH1_BASE;
		end
		ch_off = ch_rel[2:0];
	end

	// Tick arbitration: round-robin pointer first, else the other channel
	assign tick_act = fire && (op == OP_TICK) && (busy_q != '0);
	assign tc       = busy_q[rr_q] ? rr_q : ~rr_q;
	assign segs_inc = {1'b0, segs_q[tc]} + 1'b1;

	// Segment byte length, cut to the result field
	assign shifted = SH_W'(seg_len_q[tc]) << width_q[tc];
	assign blen    = shifted[BLEN_W-1:0];

	// Next state of transfers and interrupts
	always_comb begin
		busy_d     = busy_q;
		irq_en_d   = irq_en_q;
		irq_pend_d = irq_pend_q;
		rr_d       = rr_q;
		for (int i = 0; i < NUM_CH; i++) begin
			cur_src_d[i] = cur_src_q[i];
			cur_dst_d[i] = cur_dst_q[i];
			segs_d[i]    = segs_q[i];
		end
		if (is_write) begin
			if (reg_index == REG_IRQ_EN) begin
				irq_en_d = write_data[IRQ_W-1:0];
			end else if (reg_index == REG_IRQ_PEND) begin
				irq_pend_d = write_data[IRQ_W-1:0];
			end else if (reg_index == REG_CTRL) begin
				for (int i = 0; i < NUM_CH; i++) begin
					if (write_data[i] && !busy_q[i]) begin
						cur_src_d[i] = src_start_q[i][CUR_W-1:0];
						cur_dst_d[i] = dst_start_q[i][CUR_W-1:0];
						segs_d[i]    = '0;
						if (seg_cnt_q[i] == '0) begin
							// empty transfer completes at once
							if (irq_en_q[2*i+1]) irq_pend_d[2*i+1] = 1'b1;
						end else begin
							busy_d[i] = 1'b1;
						end
					end
				end
			end
		end
		if (tick_act) begin
			rr_d = ~tc;
			for (int i = 0; i < NUM_CH; i++) begin
				if (tc == i[0]) begin
					cur_src_d[i] = cur_src_q[i] + src_stride_q[i][CUR_W-1:0];
					cur_dst_d[i] = cur_dst_q[i] + dst_stride_q[i][CUR_W-1:0];
					segs_d[i]    = segs_inc[SEG_COUNT_BITS-1:0];
					if (irq_en_q[2*i]) irq_pend_d[2*i] = 1'b1;
					// count is read live, so a lowered count also ends it
					if (segs_inc >= {1'b0, seg_cnt_q[i]}) begin
						busy_d[i] = 1'b0;
						if (irq_en_q[2*i+1]) irq_pend_d[2*i+1] = 1'b1;
					end
				end
			end
		end
	end

	assign irq_now = |(irq_en_d & irq_pend_d);

	// Register read mux
	always_comb begin
		rd_val = '0;
		if (reg_index == REG_STATUS) begin
			rd_val = DATA_W'(busy_q);
		end else if (reg_index == REG_IRQ_EN) begin
			rd_val = DATA_W'(irq_en_q);
		end else if (reg_index == REG_IRQ_PEND) begin
			rd_val = DATA_W'(irq_pend_q);
		end else if (ch_hit) begin
			unique case (ch_off)
				OFF_SRC:        rd_val = src_start_q[ch_sel];
				OFF_DST:        rd_val = dst_start_q[ch_sel];
				OFF_SEG_LEN:    rd_val = DATA_W'(seg_len_q[ch_sel]);
				OFF_SEG_CNT:    rd_val = DATA_W'(seg_cnt_q[ch_sel]);
				OFF_WIDTH:      rd_val = DATA_W'(width_q[ch_sel]);
				OFF_SRC_STRIDE: rd_val = src_stride_q[ch_sel];
				OFF_DST_STRIDE: rd_val = dst_stride_q[ch_sel];
				default:        rd_val = '0;
			endcase
		end
	end

	// Result formation
	always_comb begin
		push.push   = fire;
		push.pair   = 1'b0;
		push.first  = '{kind: KIND_REG, channel: 1'b0, mem_address: '0, byte_length: '0,
			read_data: '0, last: 1'b1, irq: irq_now};
		push.second = push.first;
		unique case (op)
			OP_READ: begin
				push.first.read_data = rd_val;
			end
			OP_TICK: begin
				if (tick_act) begin
					push.pair               = 1'b1;
					push.first.kind         = KIND_RD;
					push.first.channel      = tc;
					push.first.mem_address  = DATA_W'(cur_src_q[tc]);
					push.first.byte_length  = blen;
					push.first.last         = 1'b0;
					push.second.kind        = KIND_WR;
					push.second.channel     = tc;
					push.second.mem_address = DATA_W'(cur_dst_q[tc]);
					push.second.byte_length = blen;
				end else begin
					push.first.kind = KIND_IDLE;
				end
			end
			OP_WRITE, OP_NOP: begin
			end
			default: begin
			end
		endcase
	end

	// Channel configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CH; i++) begin
				src_start_q[i]  <= '0;
				dst_start_q[i]  <= '0;
				seg_len_q[i]    <= '0;
				seg_cnt_q[i]    <= '0;
				width_q[i]      <= '0;
				src_stride_q[i] <= '0;
				dst_stride_q[i] <= '0;
			end
		end else if (is_write && ch_hit) begin
			unique case (ch_off)
				OFF_SRC:        src_start_q[ch_sel]  <= write_data;
				OFF_DST:        dst_start_q[ch_sel]  <= write_data;
				OFF_SEG_LEN:    seg_len_q[ch_sel]    <= write_data[SEG_LEN_BITS-1:0];
				OFF_SEG_CNT:    seg_cnt_q[ch_sel]    <= write_data[SEG_COUNT_BITS-1:0];
				OFF_WIDTH:      width_q[ch_sel]      <= write_data[1:0];
				OFF_SRC_STRIDE: src_stride_q[ch_sel] <= write_data;
				OFF_DST_STRIDE: dst_stride_q[ch_sel] <= write_data;
				default: begin
				end
			endcase
		end
	end

	// Transfer and interrupt state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= '0;
			irq_en_q   <= '0;
			irq_pend_q <= '0;
			rr_q       <= 1'b0;
			for (int i = 0; i < NUM_CH; i++) begin
				cur_src_q[i] <= '0;
				cur_dst_q[i] <= '0;
				segs_q[i]    <= '0;
			end
		end else if (fire) begin
			busy_q     <= busy_d;
			irq_en_q   <= irq_en_d;
			irq_pend_q <= irq_pend_d;
			rr_q       <= rr_d;
			for (int i = 0; i < NUM_CH; i++) begin
				cur_src_q[i] <= cur_src_d[i];
				cur_dst_q[i] <= cur_dst_d[i];
				segs_q[i]    <= segs_d[i];
			end
		end
	end

endmodule

FILE: rtl/tcsd_res_q.sv
// ---------------------------------------------------------------------------
// tcsd_res_q: result queue
// Small queue taking one or two results per cycle and handing out one.
// ---------------------------------------------------------------------------
module tcsd_res_q import tcsd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  push_t push,
	output logic  room,
	output logic  out_valid,
	input  logic  out_ready,
	output res_t  out_res
);

	res_t                mem_q [RQ_DEPTH];
	logic [RQ_PTR_W-1:0] wr_ptr_q;
	logic [RQ_PTR_W-1:0] rd_ptr_q;
	logic [RQ_CNT_W-1:0] count_q;
	logic [RQ_PTR_W-1:0] wr_ptr_nx;
	logic                pop;
	logic [RQ_CNT_W-1:0] push_n;

	// Room for a full result pair
	assign room      = (count_q <= RQ_CNT_W'(RQ_DEPTH - 2));
	assign out_valid = (count_q != '0);
	assign out_res   = mem_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;
	assign wr_ptr_nx = wr_ptr_q + 1'b1;
	assign push_n    = !push.push ? RQ_CNT_W'(0) : (push.pair ? RQ_CNT_W'(2) : RQ_CNT_W'(1));

	// Storage
	always_ff @(posedge clk) begin
		if (push.push) begin
			mem_q[wr_ptr_q] <= push.first;
			if (push.pair) mem_q[wr_ptr_nx] <= push.second;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + RQ_PTR_W'(push_n);
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q  <= count_q + push_n - RQ_CNT_W'(pop);
		end
	end

endmodule
